// ===== hw/rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the motion qualifier block.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned LOCK_W       = 17;
  localparam int unsigned STREAK_W     = 3;
  localparam int unsigned TOL_DIV      = 10;
  localparam int unsigned TOL_W        = $clog2(TOL_DIV + 1);
  localparam int unsigned CFG_ADDR_W   = 3;

  localparam logic [STREAK_W-1:0] STREAK_LIMIT = STREAK_W'(3);
  localparam logic [STREAK_W-1:0] STREAK_MAX   = STREAK_W'(7);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WARMUP    = 3'd0,
    CFG_MIN_EDGE  = 3'd1,
    CFG_COOLDOWN  = 3'd2,
    CFG_ACTUATION = 3'd3,
    CFG_POST_LOCK = 3'd4,
    CFG_STABLE    = 3'd5,
    CFG_AUDIO     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TRACK_NONE = 2'd0,
    TRACK_RAIN = 2'd1,
    TRACK_DRY  = 2'd2
  } track_e;

  // Result item, fields listed from the highest bit down, matching m_axis_tdata.
  typedef struct packed {
    logic   armed;
    logic   noise_rejected;
    logic   start_actuator;
    track_e play_track;
    logic   motion_accepted;
  } result_t;

endpackage

// ===== hw/rtl/pir_motion_qualifier.sv =====
// ----------------------------------------------------------------------------
// pir_motion_qualifier
// Qualifies motion sensor edges per millisecond tick item: warm-up, chatter,
// periodic noise, cooldown, rain actuation with lockout and re-arm.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                             Payload
//  s_axis    in   tvalid/tready/tdata[7:0]            pir_level, rain_now
//  m_axis    out  tvalid/tready/tdata[7:0]            result fields
//  cfg       in   cfg_valid_i/cfg_ready_o/addr/data   register writes
//
// Each tick item is handled in the cycle it is accepted; its result enters a
// two-entry output buffer, which m_axis drains in order. One item per cycle is
// sustained, limited only by the output buffer filling under backpressure.
// Reset clears all state to its idle values; config writes are always taken.
// Elapsed times are kept as running counters rather than timestamps.
// ----------------------------------------------------------------------------
module pir_motion_qualifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] pir_level, [1] rain_now
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] motion_accepted, [2:1] play_track,
                                     // [3] start_actuator, [4] noise_rejected,
                                     // [5] armed
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmq_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [pmq_pkg::CFG_W-1:0]      cfg_data_i
);
  import pmq_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] warmup_q, min_edge_q, cooldown_q, actuation_q, post_lock_q, stable_q;
  logic             audio_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q    <= CFG_W'(30000);
      min_edge_q  <= CFG_W'(200);
      cooldown_q  <= CFG_W'(5000);
      actuation_q <= CFG_W'(25000);
      post_lock_q <= CFG_W'(15000);
      stable_q    <= CFG_W'(3000);
      audio_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_WARMUP:    warmup_q    <= cfg_data_i;
        CFG_MIN_EDGE:  min_edge_q  <= cfg_data_i;
        CFG_COOLDOWN:  cooldown_q  <= cfg_data_i;
        CFG_ACTUATION: actuation_q <= cfg_data_i;
        CFG_POST_LOCK: post_lock_q <= cfg_data_i;
        CFG_STABLE:    stable_q    <= cfg_data_i;
        CFG_AUDIO:     audio_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Qualifier state.
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] low_el_q, low_el_d;
  logic [TIME_W-1:0] since_hdl_q, since_hdl_d;
  logic [TIME_W-1:0] since_trig_q, since_trig_d;
  logic [TIME_W-1:0] since_run_q, since_run_d;
  logic [LOCK_W-1:0] lock_q, lock_d;
  logic prev_q, prev_d, pend_q, pend_d, armed_q, armed_d, skip_q, skip_d;
  logic waiting_q, waiting_d, trig_seen_q, trig_seen_d;

  logic              accept_in, level, rain, warm_done, pend;
  logic              handled, accepted, noise_chk, is_noise;
  logic [LOCK_W-1:0] lock_cur;
  logic [TIME_W-1:0] low_cur, dt;
  result_t           res;

  assign accept_in = s_axis_tvalid && s_axis_tready;
  assign level     = s_axis_tdata[0];
  assign rain      = s_axis_tdata[1];
  assign warm_done = now_q >= TIME_W'(warmup_q);
  assign dt        = trig_seen_q ? since_trig_q : '0;

  pmq_noise u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .check_i (noise_chk),
    .dt_i    (dt),
    .noise_o (is_noise)
  );

  always_comb begin
    now_d       = now_q;
    prev_d      = prev_q;
    armed_d     = armed_q;
    skip_d      = skip_q;
    waiting_d   = waiting_q;
    trig_seen_d = trig_seen_q;
    lock_d      = lock_q;
    low_el_d    = low_el_q;
    since_hdl_d = since_hdl_q;
    since_trig_d = since_trig_q;
    since_run_d = since_run_q;
    pend_d      = pend_q;
    lock_cur    = lock_q;
    low_cur     = low_el_q;
    pend        = pend_q || (armed_q && level && !prev_q);
    handled     = 1'b0;
    accepted    = 1'b0;
    noise_chk   = 1'b0;
    res         = '0;

    if (accept_in) begin
      prev_d = level;
      if (warm_done) begin
        if (!armed_q) begin
          if (lock_q != '0) begin
            lock_cur = lock_q - LOCK_W'(1);
          end
          lock_d = lock_cur;
          if (lock_cur == '0) begin
            if (!level) begin
              if (!waiting_q) begin
                waiting_d = 1'b1;
                low_cur   = '0;
              end
              if (low_cur >= TIME_W'(stable_q)) begin
                pend    = 1'b0;
                skip_d  = 1'b1;
                armed_d = 1'b1;
              end
            end else begin
              waiting_d = 1'b0;
            end
          end
        end else if (pend) begin
          pend = 1'b0;
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (since_hdl_q >= TIME_W'(min_edge_q)) begin
            handled   = 1'b1;
            noise_chk = 1'b1;
            if (is_noise) begin
              res.noise_rejected = 1'b1;
            end else if (since_run_q > TIME_W'(cooldown_q)) begin
              accepted    = 1'b1;
              trig_seen_d = 1'b1;
              res.motion_accepted = 1'b1;
              if (audio_q) begin
                res.play_track = rain ? TRACK_RAIN : TRACK_DRY;
              end
              if (rain) begin
                res.start_actuator = 1'b1;
                armed_d   = 1'b0;
                waiting_d = 1'b0;
                skip_d    = 1'b0;
                lock_d    = LOCK_W'(actuation_q) + LOCK_W'(post_lock_q);
              end
            end
          end
        end
      end
      pend_d       = pend;
      now_d        = now_q + TIME_W'(1);
      low_el_d     = low_cur + TIME_W'(1);
      // A counter restarted on this tick reads one on the next tick.
      since_hdl_d  = handled  ? TIME_W'(1) : since_hdl_q + TIME_W'(1);
      since_trig_d = accepted ? TIME_W'(1) : since_trig_q + TIME_W'(1);
      since_run_d  = accepted ? TIME_W'(1) : since_run_q + TIME_W'(1);
      res.armed    = armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      low_el_q     <= '0;
      since_hdl_q  <= '0;
      since_trig_q <= '0;
      since_run_q  <= '0;
      lock_q       <= '0;
      prev_q       <= 1'b0;
      pend_q       <= 1'b0;
      armed_q      <= 1'b1;
      skip_q       <= 1'b0;
      waiting_q    <= 1'b0;
      trig_seen_q  <= 1'b0;
    end else begin
      now_q        <= now_d;
      low_el_q     <= low_el_d;
      since_hdl_q  <= since_hdl_d;
      since_trig_q <= since_trig_d;
      since_run_q  <= since_run_d;
      lock_q       <= lock_d;
      prev_q       <= prev_d;
      pend_q       <= pend_d;
      armed_q      <= armed_d;
      skip_q       <= skip_d;
      waiting_q    <= waiting_d;
      trig_seen_q  <= trig_seen_d;
    end
  end

  // Two-entry result buffer so a new item is taken while a result waits.
  result_t    buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign s_axis_tready = count_q != 2'd2;
  assign m_axis_tvalid = count_q != 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {2'b00, buf_q[rd_ptr_q]};

  always_comb begin
    count_d = count_q + {1'b0, accept_in} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (accept_in) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/pmq_noise.sv =====
// ----------------------------------------------------------------------------
// pmq_noise
// Periodic noise filter: tracks the last trigger interval and a streak of
// intervals that match within the tolerance.
// ----------------------------------------------------------------------------
module pmq_noise (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      check_i,
  input  logic [pmq_pkg::TIME_W-1:0] dt_i,
  output logic                      noise_o
);
  import pmq_pkg::*;

  logic [TIME_W-1:0]       last_int_q, last_int_d;
  logic [STREAK_W-1:0]     streak_q, streak_d;
  logic [STREAK_W-1:0]     streak_nx;
  logic [TIME_W-1:0]       diff;
  logic [TIME_W+TOL_W-1:0] diff_scaled;
  logic                    in_band;

  always_comb begin
    diff = (dt_i >= last_int_q) ? (dt_i - last_int_q) : (last_int_q - dt_i);
    // last / div >= diff is the same as last >= diff * div for integers.
    diff_scaled = (TIME_W+TOL_W)'(diff) * (TIME_W+TOL_W)'(TOL_DIV);
    in_band = (TIME_W+TOL_W)'(last_int_q) >= diff_scaled;
  end

  // The verdict does not depend on check_i, so the caller may gate on it freely.
  always_comb begin
    if (!in_band) begin
      streak_nx = '0;
    end else if (streak_q < STREAK_MAX) begin
      streak_nx = streak_q + STREAK_W'(1);
    end else begin
      streak_nx = streak_q;
    end
    noise_o = (dt_i != '0) && (last_int_q != '0) && (streak_nx >= STREAK_LIMIT);
  end

  always_comb begin
    last_int_d = last_int_q;
    streak_d   = streak_q;
    if (check_i && (dt_i != '0)) begin
      last_int_d = dt_i;
      if (last_int_q == '0) begin
        streak_d = '0;
      end else begin
        streak_d = streak_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_int_q <= '0;
      streak_q   <= '0;
    end else begin
      last_int_q <= last_int_d;
      streak_q   <= streak_d;
    end
  end

endmodule

// ===== tb/tb_pir_motion_qualifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pir_motion_qualifier
// Self-checking bench for the motion qualifier. Tick items go in on the
// s_axis side and a behavioral model of the qualifier predicts one result per
// tick: warm-up hold, chatter drop, periodic noise rejection, cooldown, track
// selection, rain actuation, lockout countdown and re-arm. Results on the
// m_axis side are compared in order. Both sides idle at random, and register
// settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_pir_motion_qualifier;
  import pmq_pkg::*;

  localparam int ITEM_TARGET  = 1450;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {STYLE_PULSE, STYLE_PERIODIC, STYLE_NOISE} pattern_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  int  items_sent   = 0;
  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  int  stall_left   = 0;
  bit  sender_idles = 1'b0;
  bit  sink_stalls  = 1'b0;

  result_t pending_results[$];

  // Register copies, at their reset values.
  logic [CFG_W-1:0] cfg_warmup     = 16'd30000;
  logic [CFG_W-1:0] cfg_min_edge   = 16'd200;
  logic [CFG_W-1:0] cfg_cooldown   = 16'd5000;
  logic [CFG_W-1:0] cfg_actuation  = 16'd25000;
  logic [CFG_W-1:0] cfg_post_lock  = 16'd15000;
  logic [CFG_W-1:0] cfg_stable_low = 16'd3000;
  logic             cfg_audio      = 1'b1;

  // Qualifier state, at its reset values.
  logic [TIME_W-1:0]   tick_cnt     = '0;
  logic                lvl_prev     = 1'b0;
  logic                rise_latched = 1'b0;
  logic                arm_q        = 1'b1;
  logic                skip_rise    = 1'b0;
  logic                low_wait     = 1'b0;
  logic [TIME_W-1:0]   low_since    = '0;
  logic [LOCK_W-1:0]   lock_cnt     = '0;
  logic [TIME_W-1:0]   last_edge_t  = '0;
  logic [TIME_W-1:0]   last_trig_t  = '0;
  logic                trig_seen    = 1'b0;
  logic [TIME_W-1:0]   last_run_t   = '0;
  logic [TIME_W-1:0]   prev_gap     = '0;
  logic [STREAK_W-1:0] streak       = '0;

  pir_motion_qualifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: mostly ready, with short and occasional long stalls.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 99) < 12)
        stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
  end

  function automatic result_t qualify_tick(input logic lvl, input logic rain);
    result_t           r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] dev;
    logic              is_noise;
    r = '0;
    r.play_track = TRACK_NONE;
    t = tick_cnt;
    if (arm_q && lvl && !lvl_prev) rise_latched = 1'b1;
    lvl_prev = lvl;
    if (t >= TIME_W'(cfg_warmup)) begin
      if (!arm_q) begin
        if (lock_cnt != '0) lock_cnt = lock_cnt - 1'b1;
        if (lock_cnt == '0) begin
          if (!lvl) begin
            if (!low_wait) begin
              low_wait  = 1'b1;
              low_since = t;
            end
            if (TIME_W'(t - low_since) >= TIME_W'(cfg_stable_low)) begin
              rise_latched = 1'b0;
              skip_rise    = 1'b1;
              arm_q        = 1'b1;
            end
          end else begin
            low_wait = 1'b0;
          end
        end
      end else if (rise_latched) begin
        rise_latched = 1'b0;
        if (skip_rise) begin
          skip_rise = 1'b0;
        end else if (TIME_W'(t - last_edge_t) >= TIME_W'(cfg_min_edge)) begin
          gap = trig_seen ? TIME_W'(t - last_trig_t) : '0;
          last_edge_t = t;
          is_noise = 1'b0;
          // A zero interval leaves the periodicity history untouched.
          if (gap != '0) begin
            if (prev_gap == '0) begin
              prev_gap = gap;
              streak   = '0;
            end else begin
              dev = (gap >= prev_gap) ? gap - prev_gap : prev_gap - gap;
              if (dev <= prev_gap / TOL_DIV) begin
                if (streak < STREAK_MAX) streak = streak + 1'b1;
              end else begin
                streak = '0;
              end
              prev_gap = gap;
              is_noise = (streak >= STREAK_LIMIT);
            end
          end
          if (is_noise) begin
            r.noise_rejected = 1'b1;
          end else if (TIME_W'(t - last_run_t) > TIME_W'(cfg_cooldown)) begin
            last_trig_t = t;
            trig_seen   = 1'b1;
            last_run_t  = t;
            r.motion_accepted = 1'b1;
            if (cfg_audio) r.play_track = rain ? TRACK_RAIN : TRACK_DRY;
            if (rain) begin
              r.start_actuator = 1'b1;
              arm_q        = 1'b0;
              low_wait     = 1'b0;
              low_since    = '0;
              skip_rise    = 1'b0;
              rise_latched = 1'b0;
              lock_cnt     = {1'b0, cfg_actuation} + {1'b0, cfg_post_lock};
            end
          end
        end
      end
    end
    tick_cnt = t + 1'b1;
    r.armed = arm_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Register writes, tick predictions and result checks, all on the rising edge.
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_WARMUP:    cfg_warmup     = cfg_data_i;
          CFG_MIN_EDGE:  cfg_min_edge   = cfg_data_i;
          CFG_COOLDOWN:  cfg_cooldown   = cfg_data_i;
          CFG_ACTUATION: cfg_actuation  = cfg_data_i;
          CFG_POST_LOCK: cfg_post_lock  = cfg_data_i;
          CFG_STABLE:    cfg_stable_low = cfg_data_i;
          CFG_AUDIO:     cfg_audio      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(qualify_tick(s_axis_tdata[0], s_axis_tdata[1]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[5:0]);
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual 0x%02h",
                   $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("motion_accepted", {1'b0, want.motion_accepted},
                      {1'b0, got.motion_accepted});
          check_field("play_track", want.play_track, got.play_track);
          check_field("start_actuator", {1'b0, want.start_actuator},
                      {1'b0, got.start_actuator});
          check_field("noise_rejected", {1'b0, want.noise_rejected},
                      {1'b0, got.noise_rejected});
          check_field("armed", {1'b0, want.armed}, {1'b0, got.armed});
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_tick(input logic lvl, input logic rain);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rain, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] warm, input logic [CFG_W-1:0] min_edge,
                          input logic [CFG_W-1:0] cool, input logic [CFG_W-1:0] act,
                          input logic [CFG_W-1:0] post, input logic [CFG_W-1:0] stable,
                          input logic [CFG_W-1:0] audio);
    write_reg(CFG_WARMUP, warm);
    write_reg(CFG_MIN_EDGE, min_edge);
    write_reg(CFG_COOLDOWN, cool);
    write_reg(CFG_ACTUATION, act);
    write_reg(CFG_POST_LOCK, post);
    write_reg(CFG_STABLE, stable);
    write_reg(CFG_AUDIO, audio);
  endtask

  // Sends n ticks, bit k of each vector going out with tick k.
  task automatic send_pattern(input logic [31:0] levels, input logic [31:0] rains, input int n);
    for (int k = 0; k < n; k++) send_tick(levels[k], rains[k]);
  endtask

  task automatic send_train(input pattern_e style, input int n, input int rain_pct);
    int  period;
    int  hi;
    int  lo;
    int  k;
    bit  rain;
    period = $urandom_range(2, 25);
    k = 0;
    while (k < n) begin
      rain = ($urandom_range(0, 99) < rain_pct);
      if ($urandom_range(0, 59) == 0) wait_idle();
      if (style == STYLE_NOISE) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        k++;
      end else begin
        if (style == STYLE_PULSE) begin
          hi = $urandom_range(1, 4);
          lo = $urandom_range(1, 20);
        end else begin
          hi = 1;
          lo = period - 1;
          // Mostly within the tolerance band, sometimes well outside it.
          if ($urandom_range(0, 3) == 0) lo = lo + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 15) == 0) lo = lo + $urandom_range(3, 10);
          if (lo < 1) lo = 1;
        end
        for (int j = 0; j < hi && k < n; j++) begin
          send_tick(1'b1, rain);
          k++;
        end
        for (int j = 0; j < lo && k < n; j++) begin
          send_tick(1'b0, rain);
          k++;
        end
      end
    end
  endtask

  // Edges seen during warm-up are held as one pending edge and handled once it ends.
  task automatic test_warmup();
    set_regs(16'd5, 16'd0, 16'd0, 16'd2, 16'd1, 16'd2, 16'd1);
    send_pattern(32'h05, 32'h00, 6);
  endtask

  task automatic test_chatter();
    write_reg(CFG_MIN_EDGE, 16'd4);
    send_pattern(32'h15, 32'h00, 5);
  endtask

  task automatic test_periodic_noise();
    write_reg(CFG_MIN_EDGE, 16'd0);
    send_pattern(32'h155, 32'h00, 10);
  endtask

  // Rain disarms, a high level during the low timing restarts it, and the
  // first edge after re-arming is dropped.
  task automatic test_rain_lockout();
    sender_idles = 1'b1;
    sink_stalls  = 1'b1;
    send_pattern(32'h511, 32'h01, 12);
  endtask

  task automatic test_audio_off();
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFE);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_pattern(32'h01, 32'h01, 3);
  endtask

  task automatic test_extremes();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_train(STYLE_NOISE, 20, 50);
    write_reg(CFG_WARMUP, 16'h0000);
    send_train(STYLE_PULSE, 20, 0);
    write_reg(CFG_MIN_EDGE, 16'h0000);
    send_train(STYLE_PULSE, 20, 0);
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0001);
    send_train(STYLE_NOISE, 30, 50);
  endtask

  task automatic test_random_traffic();
    int       warm;
    int       pick;
    pattern_e style;
    int       rain_pct;
    while (items_sent < ITEM_TARGET - 150) begin
      warm = ($urandom_range(0, 9) < 7) ? 0 : int'(tick_cnt) + $urandom_range(1, 60);
      if ($urandom_range(0, 49) == 0) warm = $urandom_range(0, 65535);
      if (warm > 65535) warm = 65535;
      set_regs(16'(warm), 16'($urandom_range(0, 12)), 16'($urandom_range(0, 30)),
               16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
               16'($urandom_range(0, 15)),
               {15'($urandom), 1'($urandom_range(0, 9) < 8)});
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      sender_idles = ($urandom_range(0, 2) != 0);
      sink_stalls  = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      style = (pick < 45) ? STYLE_PULSE : (pick < 80) ? STYLE_PERIODIC : STYLE_NOISE;
      pick = $urandom_range(0, 2);
      rain_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
      send_train(style, $urandom_range(40, 120), rain_pct);
    end
  endtask

  // The longest lockout: both times at their maximum, and the low time too.
  task automatic test_long_lockout();
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0001);
    send_pattern(32'h0, 32'h0, 32);
    send_pattern(32'h0, 32'h0, 20);
    set_regs(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_pattern(32'h05, 32'h04, 3);
    send_train(STYLE_NOISE, 40, 50);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_warmup();
    test_chatter();
    test_periodic_noise();
    test_rain_lockout();
    test_audio_off();
    test_extremes();
    test_random_traffic();
    test_long_lockout();
    wait_idle();
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pmq_pkg.sv
hw/rtl/pmq_noise.sv
hw/rtl/pir_motion_qualifier.sv
tb/tb_pir_motion_qualifier.sv
